// ----- rtl/core/mss_pkg.sv -----
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types, constants and the note period tables of the score sequencer.
// ----------------------------------------------------------------------------
package mss_pkg;

  localparam int SCORE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(SCORE_DEPTH);
  localparam int CNT_W       = $clog2(SCORE_DEPTH + 1);

  // request codes
  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_TICK = 2'd1;
  localparam logic [1:0] FUNC_STOP = 2'd2;

  // score characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HALF   = 8'h21;  // '!'
  localparam logic [7:0] CH_SHARP  = 8'h23;  // '#'
  localparam logic [7:0] CH_DOUBLE = 8'h2D;  // '-'
  localparam logic [7:0] CH_DOT    = 8'h2E;  // '.'
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_UP     = 8'h5E;  // '^'
  localparam logic [7:0] CH_DOWN   = 8'h5F;  // '_'

  localparam logic [15:0] BASE_LEN = 16'd16;
  localparam logic signed [4:0] OCT_MAX = 5'sd8;
  localparam logic signed [4:0] OCT_MIN = -5'sd8;

  localparam logic [15:0] NATURAL_TAB [7] = '{
    16'd4545, 16'd4048, 16'd3824, 16'd3401, 16'd3030, 16'd2865, 16'd2551
  };
  localparam logic [15:0] SHARP_TAB [7] = '{
    16'd4291, 16'd3824, 16'd3610, 16'd3215, 16'd2865, 16'd2702, 16'd2409
  };

  typedef struct packed {
    logic [2:0]        note;    // 0 = A .. 6 = G
    logic              sharp;
    logic signed [4:0] octave;
  } pitch_req_t;

  function automatic logic [15:0] note_period(input logic [2:0] idx, input logic sharp);
    logic [15:0] p;
    p = 16'd0;
    if (idx < 3'd7) begin
      p = sharp ? SHARP_TAB[idx] : NATURAL_TAB[idx];
    end
    return p;
  endfunction

endpackage

// ----- rtl/core/mss_pitch.sv -----
// ----------------------------------------------------------------------------
// mss_pitch
// Note period lookup with octave shift: halves per octave up, doubles with
// saturation per octave down.
// ----------------------------------------------------------------------------
module mss_pitch
  import mss_pkg::*;
(
  input  pitch_req_t  req,
  output logic [15:0] period
);

  logic [15:0] base;
  logic [4:0]  neg_oct;
  logic [23:0] wide;

  always_comb begin
    base    = note_period(req.note, req.sharp);
    neg_oct = 5'(-req.octave);
    wide    = {8'd0, base} << neg_oct[3:0];
    if (!req.octave[4]) begin
      period = base >> req.octave[3:0];
    end else if (|wide[23:16]) begin
      period = 16'hFFFF;
    end else begin
      period = wide[15:0];
    end
  end

endmodule

// ----- rtl/core/melody_score_sequencer.sv -----
// ----------------------------------------------------------------------------
// melody_score_sequencer
// Stores a score of characters and plays it note by note on ticks, driving
// a tone period and duty.
// ----------------------------------------------------------------------------
// sequence: load, stop and ticks that scan nothing go from idle straight to the
//   result; a tick that scans reads characters until it reaches a note or rest,
//   or until it ends the score, and then gives its result
// throughput: one request in flight; a scan is paced by the single read port of
//   the score memory (one character a cycle)
// reset: synchronous, clears all control and playback state; score memory kept
module melody_score_sequencer
  import mss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_symbol,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_tone_on,
  output logic [15:0] out_period,
  output logic [14:0] out_duty,
  output logic        out_playing,
  output logic        out_accepted
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]  score_len_r, score_len_nxt;
  logic [CNT_W-1:0]  rd_pos_r, rd_pos_nxt;
  logic [15:0]       tick_r, tick_nxt;
  logic              gap_r, gap_nxt;
  logic signed [4:0] oct_r, oct_nxt;
  logic              busy_r, busy_nxt;
  logic [15:0]       tone_period_r, tone_period_nxt;
  logic              tone_en_r, tone_en_nxt;
  logic              accepted_r, accepted_nxt;
  logic              sharp_r, sharp_nxt;
  logic [15:0]       dur_r, dur_nxt;
  logic              out_valid_r;

  // score memory
  logic [7:0]        score_mem [SCORE_DEPTH];
  logic [7:0]        mem_q_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CNT_W-1:0]  rd_pos_inc;

  logic              in_xfer;
  logic              emit_load;
  logic [15:0]       tick_dec;
  logic [16:0]       dur_dbl;
  logic [16:0]       dur_dot;
  logic [15:0]       dur_half;
  logic [15:0]       note_ticks;
  logic [7:0]        note_ofs;
  pitch_req_t        pitch_req;
  logic [15:0]       pitch_period;

  assign in_ready   = (state_r == ST_IDLE);
  assign in_xfer    = in_valid && in_ready;
  assign emit_load  = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign out_valid  = out_valid_r;
  assign rd_pos_inc = rd_pos_r + CNT_W'(1);
  assign tick_dec   = tick_r - 16'd1;
  assign mem_waddr  = score_len_r[ADDR_W-1:0];
  // during the scan the next character is fetched ahead
  assign mem_raddr  = (state_r == ST_SCAN) ? rd_pos_inc[ADDR_W-1:0] : rd_pos_r[ADDR_W-1:0];

  assign dur_half   = (dur_r[15:1] == 15'd0) ? 16'd1 : {1'b0, dur_r[15:1]};
  assign dur_dbl    = {dur_r, 1'b0};
  assign dur_dot    = {1'b0, dur_r} + {2'b00, dur_r[15:1]};
  assign note_ticks = (dur_r > 16'd1) ? (dur_r - 16'd1) : 16'd1;
  assign note_ofs   = mem_q_r - CH_A;

  assign pitch_req.note   = note_ofs[2:0];
  assign pitch_req.sharp  = sharp_r;
  assign pitch_req.octave = oct_r;

  mss_pitch u_pitch (
    .req    (pitch_req),
    .period (pitch_period)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      score_mem[mem_waddr] <= in_symbol;
    end
    mem_q_r <= score_mem[mem_raddr];
  end

  always_comb begin
    state_nxt       = state_r;
    score_len_nxt   = score_len_r;
    rd_pos_nxt      = rd_pos_r;
    tick_nxt        = tick_r;
    gap_nxt         = gap_r;
    oct_nxt         = oct_r;
    busy_nxt        = busy_r;
    tone_period_nxt = tone_period_r;
    tone_en_nxt     = tone_en_r;
    accepted_nxt    = accepted_r;
    sharp_nxt       = sharp_r;
    dur_nxt         = dur_r;
    mem_we          = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          accepted_nxt = 1'b0;
          state_nxt    = ST_EMIT;
          case (in_func)
            FUNC_LOAD: begin
              if (!busy_r) begin
                if (score_len_r < CNT_W'(SCORE_DEPTH)) begin
                  mem_we        = 1'b1;
                  score_len_nxt = score_len_r + CNT_W'(1);
                  accepted_nxt  = 1'b1;
                end
                if (in_last) begin
                  busy_nxt   = 1'b1;
                  rd_pos_nxt = '0;
                  tick_nxt   = 16'd1;
                  gap_nxt    = 1'b0;
                end
              end
            end
            FUNC_TICK: begin
              if (tick_r != 16'd0) begin
                tick_nxt = tick_dec;
                if (tick_dec == 16'd0) begin
                  tone_en_nxt = 1'b0;
                  if (gap_r) begin
                    tick_nxt = 16'd1;
                    gap_nxt  = 1'b0;
                  end else begin
                    sharp_nxt = 1'b0;
                    dur_nxt   = BASE_LEN;
                    state_nxt = ST_FETCH;
                  end
                end
              end
            end
            FUNC_STOP: begin
              if (busy_r) begin
                rd_pos_nxt = score_len_r;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_FETCH: begin
        if (rd_pos_r < score_len_r) begin
          state_nxt = ST_SCAN;
        end else begin
          busy_nxt      = 1'b0;
          oct_nxt       = '0;
          gap_nxt       = 1'b0;
          score_len_nxt = '0;
          rd_pos_nxt    = '0;
          tick_nxt      = 16'd0;
          state_nxt     = ST_EMIT;
        end
      end

      ST_SCAN: begin
        rd_pos_nxt = rd_pos_inc;
        state_nxt  = (rd_pos_inc < score_len_r) ? ST_SCAN : ST_FETCH;
        unique case (mem_q_r) inside
          CH_NUL: begin
            rd_pos_nxt = score_len_r;  // end of score
            state_nxt  = ST_FETCH;
          end
          [CH_A:CH_G]: begin
            tone_period_nxt = pitch_period;
            tone_en_nxt     = 1'b1;
            tick_nxt        = note_ticks;
            gap_nxt         = 1'b1;
            state_nxt       = ST_EMIT;
          end
          CH_SPACE: begin
            tick_nxt  = note_ticks;
            gap_nxt   = 1'b1;
            state_nxt = ST_EMIT;
          end
          CH_SHARP: sharp_nxt = 1'b1;
          CH_UP: begin
            if (oct_r < OCT_MAX) oct_nxt = oct_r + 5'sd1;
          end
          CH_DOWN: begin
            if (oct_r > OCT_MIN) oct_nxt = oct_r - 5'sd1;
          end
          CH_HALF:   dur_nxt = dur_half;
          CH_DOUBLE: dur_nxt = dur_dbl[16] ? 16'hFFFF : dur_dbl[15:0];
          CH_DOT:    dur_nxt = dur_dot[16] ? 16'hFFFF : dur_dot[15:0];
          default: begin
          end
        endcase
      end

      ST_EMIT: begin
        if (emit_load) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      score_len_r   <= '0;
      rd_pos_r      <= '0;
      tick_r        <= '0;
      gap_r         <= 1'b0;
      oct_r         <= '0;
      busy_r        <= 1'b0;
      tone_period_r <= '0;
      tone_en_r     <= 1'b0;
      accepted_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      score_len_r   <= score_len_nxt;
      rd_pos_r      <= rd_pos_nxt;
      tick_r        <= tick_nxt;
      gap_r         <= gap_nxt;
      oct_r         <= oct_nxt;
      busy_r        <= busy_nxt;
      tone_period_r <= tone_period_nxt;
      tone_en_r     <= tone_en_nxt;
      accepted_r    <= accepted_nxt;
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // scan scratch and result payload
  always_ff @(posedge clk) begin
    sharp_r <= sharp_nxt;
    dur_r   <= dur_nxt;
    if (emit_load) begin
      out_tone_on  <= tone_en_r;
      out_period   <= tone_period_r;
      out_duty     <= tone_period_r[15:1];
      out_playing  <= busy_r;
      out_accepted <= accepted_r;
    end
  end

  // idle player keeps no leftover playback state
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (oct_r == 5'sd0) && !gap_r && (tick_r == 16'd0) && !tone_en_r)
    else $error("playback state left over while not playing");

  a_oct_range: assert property (@(posedge clk) disable iff (!rst_n)
    (oct_r <= OCT_MAX) && (oct_r >= OCT_MIN))
    else $error("octave shift out of range");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    score_len_r <= CNT_W'(SCORE_DEPTH))
    else $error("score length beyond memory depth");

  a_scan_in_score: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (rd_pos_r < score_len_r) && busy_r)
    else $error("scan outside the stored score");

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !busy_r && (state_r == ST_IDLE))
    else $error("score write during playback");

endmodule
